// ===== design/bitset_with_next_set_scan_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitset scan block
// Concurrent checks with an active-high reset disable.
// ----------------------------------------------------------------------------
`ifndef BITSET_WITH_NEXT_SET_SCAN_DEFINES_SVH
`define BITSET_WITH_NEXT_SET_SCAN_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define BWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the antecedent
`define BWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bws_pkg.sv =====
// ----------------------------------------------------------------------------
// bws_pkg
// Shared widths, codes and control types of the bitset scan block.
// ----------------------------------------------------------------------------
package bws_pkg;

   // field widths
   localparam int LIT_W      = 20;
   localparam int CNT_W      = 11;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   // store geometry
   localparam int MAX_ENTRIES = 1024;
   localparam int WORD_BITS   = 64;
   localparam int WORD_COUNT  = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);

   // largest usable limit that the count register can express
   localparam int LIMIT_CAP = (MAX_ENTRIES > (2 ** CNT_W) - 1) ?
                              (2 ** CNT_W) - 1 : MAX_ENTRIES;

   // register reset values
   localparam logic [LIT_W-1:0] BASE_RESET  = LIT_W'(1);
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_SET       = 3'd0,
      MODE_CLEAR     = 3'd1,
      MODE_TEST      = 3'd2,
      MODE_CLEAR_ALL = 3'd3,
      MODE_RESTART   = 3'd4,
      MODE_NEXT      = 3'd5
   } mode_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_OFFSET = 1'b0,
      CSR_ENTRY_COUNT = 1'b1
   } csr_idx_type;

   // controller to datapath
   typedef struct packed {
      logic access;      // set, clear, test, clear-all or spare request accepted
      logic scan_begin;  // restart or next accepted
      logic scan_step;   // examine one bitmap word
   } bws_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;    // scan hit or ran out this cycle
   } bws_sts_type;

endpackage

// ===== design/bws_req_if.sv =====
// ----------------------------------------------------------------------------
// bws_req_if
// Request channel: valid/ready handshake with mode and literal.
// ----------------------------------------------------------------------------
interface bws_req_if
   import bws_pkg::*;
();

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [LIT_W-1:0]  literal;

   modport source (output valid, output mode, output literal, input ready);
   modport sink   (input valid, input mode, input literal, output ready);

endinterface

// ===== design/bws_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bws_rsp_if
// Response channel: valid/ready handshake with test and scan results.
// ----------------------------------------------------------------------------
interface bws_rsp_if
   import bws_pkg::*;
();

   logic             valid;
   logic             ready;
   logic             present;
   logic             found;
   logic [LIT_W-1:0] found_literal;
   logic             out_of_range;

   modport source (output valid, output present, output found,
                   output found_literal, output out_of_range, input ready);
   modport sink   (input valid, input present, input found,
                   input found_literal, input out_of_range, output ready);

endinterface

// ===== design/bws_ctl.sv =====
// ----------------------------------------------------------------------------
// bws_ctl
// Request sequencer: takes requests, runs word-by-word scans, owns the
// response valid flag.
// ----------------------------------------------------------------------------
`include "bitset_with_next_set_scan_defines.svh"

module bws_ctl
   import bws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bws_cmd_type       cmd,
   input  bws_sts_type       sts
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      is_scan;

   // take a request only when idle and the response slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_scan   = req_mode inside {MODE_RESTART, MODE_NEXT};
   assign rsp_valid = rsp_valid_ff;

   // commands
   always_comb begin
      cmd.access     = accept && !is_scan;
      cmd.scan_begin = accept && is_scan;
      cmd.scan_step  = (state_ff == ST_SCAN);
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.scan_begin) begin
               state_in = ST_SCAN;
            end else if (cmd.access) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `BWS_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !accept, "request taken over a pending response")
   `BWS_ASSERT_NOW(a_end_in_scan, clock, reset, sts.scan_end, state_ff == ST_SCAN, "scan end outside scan")
   `BWS_ASSERT_NEXT(a_scan_enters, clock, reset, cmd.scan_begin, state_ff == ST_SCAN && !rsp_valid_ff, "scan did not start")
   `BWS_ASSERT_NEXT(a_access_rsp, clock, reset, cmd.access, rsp_valid_ff && state_ff == ST_IDLE, "single-cycle request gave no response")

endmodule

// ===== design/bws_dp.sv =====
// ----------------------------------------------------------------------------
// bws_dp
// Datapath: bitmap words, scan cursor, registers, range check, one-word
// scan step and the response payload register.
// ----------------------------------------------------------------------------
module bws_dp
   import bws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [LIT_W-1:0]      req_literal,
   input  bws_cmd_type           cmd,
   output bws_sts_type           sts,
   output logic                  rsp_present,
   output logic                  rsp_found,
   output logic [LIT_W-1:0]      rsp_found_literal,
   output logic                  rsp_out_of_range
);

   localparam int CW_W = CNT_W - BIT_IDX_W;   // cursor word field

   logic [WORD_BITS-1:0]  bitmap_ff [WORD_COUNT];
   logic [WORD_BITS-1:0]  bitmap_in [WORD_COUNT];
   logic [CNT_W-1:0]      cursor_ff, cursor_in;
   logic [LIT_W-1:0]      base_ff, base_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  present_ff, present_in;
   logic                  found_ff, found_in;
   logic [LIT_W-1:0]      flit_ff, flit_in;
   logic                  oor_ff, oor_in;

   logic [CNT_W-1:0]      lim;
   mode_type              mode;
   logic                  is_rw;

   logic [LIT_W:0]        diff;
   logic                  acc_ok;
   logic [WORD_IDX_W-1:0] acc_word;
   logic [WORD_BITS-1:0]  acc_mask;
   logic [WORD_BITS-1:0]  acc_rd;

   logic [CW_W-1:0]       cur_word;
   logic [CW_W-1:0]       lim_word;
   logic                  in_range;
   logic [WORD_BITS-1:0]  scan_rd;
   logic [WORD_BITS-1:0]  low_mask;
   logic [WORD_BITS-1:0]  lim_mask;
   logic [WORD_BITS-1:0]  cand;
   logic [BIT_IDX_W-1:0]  pos;
   logic                  scan_hit;
   logic                  scan_out;
   logic [CNT_W-1:0]      hit_idx;
   logic [CNT_W-1:0]      next_start;

   // effective scan limit
   assign lim = (count_ff > CNT_W'(LIMIT_CAP)) ? CNT_W'(LIMIT_CAP) : count_ff;

   assign mode  = mode_type'(req_mode);
   assign is_rw = req_mode inside {MODE_SET, MODE_CLEAR, MODE_TEST};

   // literal to entry index and range check
   assign diff     = {1'b0, req_literal} - {1'b0, base_ff};
   assign acc_ok   = !diff[LIT_W] && (diff[LIT_W-1:0] < LIT_W'(lim));
   assign acc_word = diff[BIT_IDX_W +: WORD_IDX_W];
   assign acc_mask = WORD_BITS'(1) << diff[BIT_IDX_W-1:0];
   assign acc_rd   = bitmap_ff[acc_word];

   // one scan step over the word under the cursor
   assign cur_word = cursor_ff[CNT_W-1:BIT_IDX_W];
   assign lim_word = lim[CNT_W-1:BIT_IDX_W];
   assign in_range = cursor_ff < lim;
   assign scan_rd  = bitmap_ff[cursor_ff[BIT_IDX_W +: WORD_IDX_W]];
   assign low_mask = {WORD_BITS{1'b1}} << cursor_ff[BIT_IDX_W-1:0];
   assign lim_mask = (lim_word > cur_word) ? {WORD_BITS{1'b1}} :
                     ~({WORD_BITS{1'b1}} << lim[BIT_IDX_W-1:0]);
   assign cand     = scan_rd & low_mask & lim_mask;

   // lowest set candidate bit
   always_comb begin
      pos = '0;
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (cand[k]) begin
            pos = BIT_IDX_W'(k);
         end
      end
   end

   assign scan_hit   = in_range && (|cand);
   assign hit_idx    = {cur_word, pos};
   assign next_start = {cur_word + CW_W'(1), {BIT_IDX_W{1'b0}}};
   assign scan_out   = !in_range || (!scan_hit && (next_start >= lim));

   assign sts.scan_end = cmd.scan_step && (scan_hit || scan_out);

   // registers, bitmap and cursor update
   always_comb begin
      base_in   = base_ff;
      count_in  = count_ff;
      bitmap_in = bitmap_ff;
      cursor_in = cursor_ff;

      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_BASE_OFFSET: base_in  = csr_wdata[LIT_W-1:0];
            CSR_ENTRY_COUNT: count_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      if (cmd.access) begin
         case (mode)
            MODE_SET: begin
               if (acc_ok) begin
                  bitmap_in[acc_word] = acc_rd | acc_mask;
               end
            end
            MODE_CLEAR: begin
               if (acc_ok) begin
                  bitmap_in[acc_word] = acc_rd & ~acc_mask;
               end
            end
            MODE_CLEAR_ALL: begin
               for (int w = 0; w < WORD_COUNT; w++) begin
                  bitmap_in[w] = '0;
               end
            end
            default: ;
         endcase
      end

      if (cmd.scan_begin && (mode == MODE_RESTART)) begin
         cursor_in = '0;
      end else if (cmd.scan_step) begin
         if (scan_hit) begin
            cursor_in = hit_idx + CNT_W'(1);
         end else if (scan_out) begin
            cursor_in = lim + CNT_W'(1);
         end else begin
            cursor_in = next_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            bitmap_ff[w] <= '0;
         end
         cursor_ff <= '0;
         base_ff   <= BASE_RESET;
         count_ff  <= COUNT_RESET;
      end else begin
         bitmap_ff <= bitmap_in;
         cursor_ff <= cursor_in;
         base_ff   <= base_in;
         count_ff  <= count_in;
      end
   end

   // response payload
   always_comb begin
      present_in = present_ff;
      found_in   = found_ff;
      flit_in    = flit_ff;
      oor_in     = oor_ff;
      if (cmd.access) begin
         present_in = (mode == MODE_TEST) && acc_ok && (|(acc_rd & acc_mask));
         found_in   = 1'b0;
         flit_in    = '0;
         oor_in     = is_rw && !acc_ok;
      end else if (sts.scan_end) begin
         present_in = 1'b0;
         found_in   = scan_hit;
         flit_in    = scan_hit ? (base_ff + LIT_W'(hit_idx)) : '0;
         oor_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      present_ff <= present_in;
      found_ff   <= found_in;
      flit_ff    <= flit_in;
      oor_ff     <= oor_in;
   end

   assign rsp_present       = present_ff;
   assign rsp_found         = found_ff;
   assign rsp_found_literal = flit_ff;
   assign rsp_out_of_range  = oor_ff;

endmodule

// ===== design/bitset_with_next_set_scan.sv =====
// ----------------------------------------------------------------------------
// bitset_with_next_set_scan
// Membership bitmap with set, clear, test, clear-all and a next-set scan.
//
//   port      dir   handshake      payload
//   req_chan  in    valid/ready    mode, literal
//   rsp_chan  out   valid/ready    present, found, found_literal, out_of_range
//   csr_*     in    csr_we         csr_index, csr_wdata
//
// Set, clear, test, clear-all and unused modes: response one cycle after
// the request is taken.
// Restart and next: the scan takes one bitmap word per step, from the cursor
// word up to the limit word, and stops at the first set bit or the limit; the
// word mux and first-set search in the datapath make up each step.
// A new request is taken once idle and the response slot is free or being
// taken in the same cycle.
// Synchronous reset clears the bitmap and cursor at once; no sweep.
// ----------------------------------------------------------------------------
module bitset_with_next_set_scan
   import bws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bws_req_if.sink               req_chan,
   bws_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   bws_cmd_type cmd;
   bws_sts_type sts;

   // sequencer
   bws_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // storage and scan datapath
   bws_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_chan.mode),
      .req_literal       (req_chan.literal),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_present       (rsp_chan.present),
      .rsp_found         (rsp_chan.found),
      .rsp_found_literal (rsp_chan.found_literal),
      .rsp_out_of_range  (rsp_chan.out_of_range)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitset scan block. A shadow copy of the bitmap,
// scan cursor and registers computes the response of every accepted request;
// responses are matched in order, field by field. Directed requests come
// first, then random traffic across several base/limit settings.
// ----------------------------------------------------------------------------
module tb;
   import bws_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int IDLE_PCT        = 12;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 24;
   localparam int CYCLE_LIMIT     = 500000;

   typedef struct packed {
      logic             present;
      logic             found;
      logic [LIT_W-1:0] found_literal;
      logic             out_of_range;
   } rsp_fields_type;

   // shadow of the bitmap, cursor and registers, plus the responses owed
   class bitset_scoreboard;
      logic [WORD_BITS-1:0] words [WORD_COUNT];
      int unsigned          cursor;
      logic [LIT_W-1:0]     base;
      logic [CNT_W-1:0]     count;
      rsp_fields_type       queued [$];
      int unsigned          mismatches;

      function new();
         foreach (words[i]) words[i] = '0;
         cursor     = 0;
         base       = BASE_RESET;
         count      = COUNT_RESET;
         mismatches = 0;
      endfunction

      function int unsigned scan_limit();
         return (count > MAX_ENTRIES) ? MAX_ENTRIES : count;
      endfunction

      function void apply_register(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_BASE_OFFSET: base  = value[LIT_W-1:0];
            CSR_ENTRY_COUNT: count = value[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      // walk from the cursor, skipping all-zero words
      function bit scan_forward(output int unsigned hit);
         int unsigned i;
         int unsigned w;
         int unsigned lim;
         lim = scan_limit();
         i   = cursor;
         hit = 0;
         while (i < lim) begin
            w = i / WORD_BITS;
            if (w >= WORD_COUNT) break;
            if (words[w] == '0) begin
               i = (w + 1) * WORD_BITS;
               continue;
            end
            if (words[w][i % WORD_BITS]) begin
               cursor = i + 1;
               hit    = i;
               return 1'b1;
            end
            i++;
         end
         // exhausted: park one past the limit
         cursor = lim + 1;
         return 1'b0;
      endfunction

      function void note_request(logic [MODE_W-1:0] m, logic [LIT_W-1:0] lit);
         rsp_fields_type r;
         int unsigned    idx;
         int unsigned    hit;
         r = '0;
         case (m)
            MODE_SET, MODE_CLEAR, MODE_TEST: begin
               if (lit < base || (lit - base) >= scan_limit()) begin
                  r.out_of_range = 1'b1;
               end else begin
                  idx = lit - base;
                  if (m == MODE_SET)
                     words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
                  else if (m == MODE_CLEAR)
                     words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                  else
                     r.present = words[idx / WORD_BITS][idx % WORD_BITS];
               end
            end
            MODE_CLEAR_ALL: begin
               // cursor is left alone
               foreach (words[i]) words[i] = '0;
            end
            MODE_RESTART, MODE_NEXT: begin
               if (m == MODE_RESTART) cursor = 0;
               if (scan_forward(hit)) begin
                  r.found         = 1'b1;
                  r.found_literal = LIT_W'(hit + base);
               end
            end
            default: ;
         endcase
         queued.push_back(r);
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         mismatches++;
      endtask

      task check_response(rsp_fields_type got);
         rsp_fields_type want;
         if (queued.size() == 0) begin
            report($sformatf("response with no request pending (%h)", got));
            return;
         end
         want = queued.pop_front();
         if (got.present !== want.present)
            report($sformatf("present %b, want %b", got.present, want.present));
         if (got.found !== want.found)
            report($sformatf("found %b, want %b", got.found, want.found));
         if (got.found_literal !== want.found_literal)
            report($sformatf("found_literal %h, want %h",
                             got.found_literal, want.found_literal));
         if (got.out_of_range !== want.out_of_range)
            report($sformatf("out_of_range %b, want %b",
                             got.out_of_range, want.out_of_range));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bws_req_if req_chan ();
   bws_rsp_if rsp_chan ();

   bitset_scoreboard board;
   bit               no_idle      = 1'b0;
   bit               hold_request = 1'b0;
   int unsigned      cycle_count  = 0;

   bitset_with_next_set_scan dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // offer one request, return at the edge that takes it
   task automatic send_request(logic [MODE_W-1:0] m, logic [LIT_W-1:0] lit);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= m;
      req_chan.literal <= lit;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_request(m, lit);
   endtask

   // mostly in-range set/test/scan traffic, some edges and noise
   task automatic random_request();
      logic [MODE_W-1:0] m;
      logic [LIT_W-1:0]  lit;
      int unsigned       pick;
      int unsigned       lim;
      lim  = board.scan_limit();
      pick = $urandom_range(99);
      if (pick < 34)      m = MODE_SET;
      else if (pick < 44) m = MODE_CLEAR;
      else if (pick < 60) m = MODE_TEST;
      else if (pick < 61) m = MODE_CLEAR_ALL;
      else if (pick < 69) m = MODE_RESTART;
      else if (pick < 97) m = MODE_NEXT;
      else                m = MODE_W'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 78 && lim != 0) begin
         lit = LIT_W'(board.base + $urandom_range(lim - 1));
      end else if (pick < 90) begin
         case ($urandom_range(3))
            0: lit = LIT_W'(board.base - 1);
            1: lit = board.base;
            2: lit = LIT_W'(board.base + lim - 1);
            default: lit = LIT_W'(board.base + lim);
         endcase
      end else begin
         lit = LIT_W'($urandom);
      end
      send_request(m, lit);
   endtask

   // let every response come home before touching the registers
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.queued.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.apply_register(idx, value);
      @(posedge clock);
   endtask

   // count goes out with junk in the unused upper bits
   task automatic configure(logic [LIT_W-1:0] b, logic [CNT_W-1:0] c);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      data[CNT_W-1:0] = c;
      csr_write(CSR_BASE_OFFSET, CSR_DATA_W'(b));
      csr_write(CSR_ENTRY_COUNT, data);
   endtask

   // response side: check, then pick ready for the next cycle
   initial begin : response_side
      int unsigned    hold_left;
      rsp_fields_type got;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.present, rsp_chan.found, rsp_chan.found_literal,
                   rsp_chan.out_of_range};
            board.check_response(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      logic [LIT_W-1:0] b;
      logic [CNT_W-1:0] c;
      board = new();
      req_chan.valid   <= 1'b0;
      req_chan.mode    <= MODE_SET;
      req_chan.literal <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, at reset settings (base 1, 1024 entries)
      send_request(MODE_RESTART, 20'd0);        // empty store
      send_request(MODE_NEXT, 20'hFFFFF);       // stays exhausted
      send_request(MODE_SET, 20'd1);            // first entry
      send_request(MODE_SET, 20'd1024);         // last entry
      send_request(MODE_SET, 20'd0);            // below base
      send_request(MODE_SET, 20'd1025);         // one past limit
      send_request(MODE_SET, 20'hFFFFF);
      send_request(MODE_SET, 20'd130);
      send_request(MODE_TEST, 20'd1);
      send_request(MODE_TEST, 20'd2);
      send_request(MODE_TEST, 20'd1024);
      send_request(MODE_TEST, 20'd0);
      send_request(MODE_RESTART, 20'd0);
      send_request(MODE_NEXT, 20'd0);           // skips zero words
      send_request(MODE_NEXT, 20'd0);
      send_request(MODE_NEXT, 20'd0);           // runs out
      send_request(MODE_NEXT, 20'd0);           // parked past limit
      send_request(MODE_CLEAR, 20'd1);
      send_request(MODE_CLEAR, 20'd0);
      send_request(MODE_RESTART, 20'd0);
      send_request(MODE_CLEAR_ALL, 20'h5A5A5);
      send_request(MODE_NEXT, 20'd0);           // cursor kept, store empty
      send_request(MODE_TEST, 20'd130);
      send_request(MODE_SPARE_6, 20'hFFFFF);
      send_request(MODE_SPARE_7, 20'h5A5A5);
      wait_drained();

      // random phases; the store and cursor carry over between settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin b = 20'd1;     c = 11'd1024; end
            1: begin b = 20'd0;     c = 11'd64;   end
            2: begin b = 20'd0;     c = 11'd65;   end
            3: begin b = 20'hFFF00; c = 11'd1024; end  // found literal wraps
            4: begin b = 20'hFFFFF; c = 11'd1;    end
            5: begin b = 20'd0;     c = 11'd0;    end
            6: begin b = LIT_W'($urandom); c = 11'd2047; end
            7: begin
               b = LIT_W'($urandom_range(1000, 1));
               c = CNT_W'($urandom_range(1024, 1));
            end
            8: begin b = LIT_W'($urandom); c = CNT_W'($urandom); end
            default: begin b = 20'd1; c = 11'd1024; end
         endcase
         configure(b, c);
         no_idle = (p == 2);
         // resume the kept cursor under the new limit
         send_request(MODE_NEXT, LIT_W'($urandom));
         for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
            if (p == 0 && n == 40) hold_request = 1'b1;
            random_request();
         end
         wait_drained();
      end
      no_idle = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
